@@ rtl/assert_macros.svh @@
// Assertion macros shared by the checksummed frame receiver RTL.
// Needs a clock, and for ASSERT_CLK_RST an active-high reset, passed in by the caller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge, skipped while reset is high.
`define ASSERT_CLK_RST(lbl, clk_sig, rst_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (prop)) \
    else $error(msg);

// Check a property at every rising edge, reset included.
`define ASSERT_CLK(lbl, clk_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) (prop)) else $error(msg);

`endif

@@ rtl/cfr_pkg.sv @@
// Package for the checksummed frame receiver: transaction types, codes
// and frame constants. No dependencies.
`default_nettype none

package cfr_pkg;

  localparam int MAX_WORDS = 128;
  localparam int ADDR_W    = $clog2(MAX_WORDS);

  localparam logic [7:0] HDR_FIRST  = 8'hEB;
  localparam logic [7:0] HDR_SECOND = 8'h90;
  localparam logic [7:0] TAIL_BYTE  = 8'hBE;
  localparam logic [7:0] TYPE_MASK  = 8'h01;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_GOOD     = 2'd1,
    ST_SUM_ERR  = 2'd2,
    ST_TAIL_ERR = 2'd3
  } status_t;

  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
    logic [6:0] word_index;
  } cfr_in_t;

  typedef struct packed {
    logic [1:0]  frame_status;
    logic [6:0]  word_count;
    logic        signed_flag;
    logic [15:0] word_value;
  } cfr_out_t;

  // Per-transaction status from the parser.
  typedef struct packed {
    status_t    status;
    logic [6:0] count;
    logic       flag;
  } cfr_meta_t;

  // One byte write into the payload store.
  typedef struct packed {
    logic              wen;
    logic              hi;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } cfr_wr_t;

endpackage

`default_nettype wire

@@ rtl/cfr_store.sv @@
// Payload store: two byte-wide synchronous memories (low and high byte
// of each word), one write and one registered read per cycle. Uses cfr_pkg.
`default_nettype none

module cfr_store (
  input  wire logic                   clk,
  input  wire cfr_pkg::cfr_wr_t       wr,
  input  wire logic                   rd_en,
  input  wire logic [cfr_pkg::ADDR_W-1:0] rd_addr,
  output logic [15:0]                 rd_word
);
  import cfr_pkg::*;

  logic [7:0] mem_lo [MAX_WORDS];
  logic [7:0] mem_hi [MAX_WORDS];
  logic [7:0] rd_lo;
  logic [7:0] rd_hi;

  always_ff @(posedge clk) begin
    if (wr.wen && !wr.hi) begin
      mem_lo[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_lo <= mem_lo[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.wen && wr.hi) begin
      mem_hi[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_hi <= mem_hi[rd_addr];
    end
  end

  assign rd_word = {rd_hi, rd_lo};

endmodule

`default_nettype wire

@@ rtl/cfr_parser.sv @@
// Frame parser: header hunt, length, payload, checksum and tail phases,
// one byte per cycle while take is high, with a running sum. Uses cfr_pkg.
`default_nettype none

module cfr_parser (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             take,
  input  wire logic [7:0]       rx_byte,
  output cfr_pkg::cfr_meta_t    meta,
  output cfr_pkg::cfr_wr_t      wr
);
  import cfr_pkg::*;

  typedef enum logic [4:0] {
    PH_HUNT    = 5'b00001,
    PH_LEN     = 5'b00010,
    PH_PAYLOAD = 5'b00100,
    PH_CSUM    = 5'b01000,
    PH_TAIL    = 5'b10000
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] pos, pos_next;
  logic [6:0] words, words_next;
  logic       flag, flag_next;
  logic [7:0] sum, sum_next;
  logic [7:0] rsum, rsum_next;
  logic [7:0] pos_inc;
  status_t    status;

  assign pos_inc = pos + 8'd1;

  always_comb begin
    phase_next = phase;
    pos_next   = pos;
    words_next = words;
    flag_next  = flag;
    sum_next   = sum;
    rsum_next  = rsum;
    status     = ST_NONE;
    wr.wen     = 1'b0;
    wr.hi      = pos[0];
    wr.addr    = pos[ADDR_W:1];
    wr.data    = rx_byte;
    if (take) begin
      unique case (phase)
        PH_HUNT: begin
          if (pos == 8'd0) begin
            if (rx_byte == HDR_FIRST) begin
              pos_next = 8'd1;
            end
          end else begin
            // a failed second byte is never taken as a new header start
            pos_next = 8'd0;
            if (rx_byte == HDR_SECOND) begin
              phase_next = PH_LEN;
            end
          end
        end
        PH_LEN: begin
          words_next = rx_byte[7:1];
          flag_next  = |(rx_byte & TYPE_MASK);
          sum_next   = 8'd0;
          pos_next   = 8'd0;
          phase_next = (rx_byte[7:1] == 7'd0) ? PH_CSUM : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          wr.wen   = 1'b1;
          sum_next = sum + rx_byte;
          if (pos_inc >= {words, 1'b0}) begin
            pos_next   = 8'd0;
            phase_next = PH_CSUM;
          end else begin
            pos_next = pos_inc;
          end
        end
        PH_CSUM: begin
          rsum_next  = rx_byte;
          phase_next = PH_TAIL;
        end
        PH_TAIL: begin
          if (rx_byte == TAIL_BYTE) begin
            status = (sum == rsum) ? ST_GOOD : ST_SUM_ERR;
          end else begin
            status = ST_TAIL_ERR;
          end
          phase_next = PH_HUNT;
          pos_next   = 8'd0;
        end
        default: begin
          phase_next = PH_HUNT;
          pos_next   = 8'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      pos   <= 8'd0;
      words <= 7'd0;
      flag  <= 1'b0;
      sum   <= 8'd0;
      rsum  <= 8'd0;
    end else begin
      phase <= phase_next;
      pos   <= pos_next;
      words <= words_next;
      flag  <= flag_next;
      sum   <= sum_next;
      rsum  <= rsum_next;
    end
  end

  // Report the count and flag as they stand after this byte.
  assign meta.status = status;
  assign meta.count  = words_next;
  assign meta.flag   = flag_next;

endmodule

`default_nettype wire

@@ rtl/checksummed_frame_receiver.sv @@
// Top level of the checksummed frame receiver: parser, payload store and
// the two-stage result path. Uses cfr_pkg, cfr_parser, cfr_store, assert_macros.svh.
`default_nettype none

// Byte-stream frame receiver. Each input transaction is either a received
// byte (command 0) or a read of a stored payload word (command 1), and each
// gives exactly one result transaction. Frames are 0xEB 0x90, a length byte
// (word count << 1 | signed flag), two bytes per word low byte first, an
// 8-bit additive checksum of the payload, and the tail 0xBE; the tail byte
// reports good frame, checksum error or tail error, every other byte reports
// nothing completed. word_count and signed_flag always show the latest
// length byte, including its effect on the same transaction. The block
// takes one transaction per cycle while item_stall is low; a result passes
// through stage one, which holds the registered read of the payload
// memories, and then the output register. Stage one holds while the
// output is stalled, so one more transaction is taken behind a waiting
// result before item_stall rises. A word read in the cycle right after its
// last byte was written sees the new data, since the write lands at an
// earlier edge than the read. Reading a word that no frame has written
// returns undefined data. No clearing pass runs after reset.
module checksummed_frame_receiver (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire cfr_pkg::cfr_in_t  item,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output cfr_pkg::cfr_out_t      result
);
  import cfr_pkg::*;

  `include "assert_macros.svh"

  logic      accept;
  logic      take;
  logic      rd_en;
  logic      s1_valid;
  logic      s1_adv;
  logic      s1_read;
  cfr_meta_t s1_meta;
  cfr_meta_t meta;
  cfr_wr_t   wr;
  logic [15:0] rd_word;

  // Accept while stage one is empty or moving on this cycle.
  assign s1_adv     = s1_valid && (!result_valid || !result_stall);
  assign item_stall = s1_valid && !s1_adv;
  assign accept     = item_valid && !item_stall;
  assign take       = accept && (item.command == CMD_BYTE);
  assign rd_en      = accept && (item.command == CMD_READ);

  cfr_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .rx_byte (item.rx_byte),
    .meta    (meta),
    .wr      (wr)
  );

  // Read data registers only load on a read, so they hold while stage one stalls.
  cfr_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (item.word_index[ADDR_W-1:0]),
    .rd_word (rd_word)
  );

  // Stage one: status beside the memory read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_read <= (item.command == CMD_READ);
      s1_meta <= meta;
    end
  end

  // Output register: advance from stage one, drop when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      result.frame_status <= s1_meta.status;
      result.word_count   <= s1_meta.count;
      result.signed_flag  <= s1_meta.flag;
      result.word_value   <= s1_read ? rd_word : 16'd0;
    end
  end

  `ASSERT_CLK_RST(a_s1_hold, clk, rst, s1_valid && !s1_adv |=> s1_valid && $stable(s1_meta), "stage one lost a stalled transaction")
  `ASSERT_CLK_RST(a_read_no_status, clk, rst, s1_valid && s1_read |-> s1_meta.status == ST_NONE, "read command carries a frame status")
  `ASSERT_CLK_RST(a_stall_full, clk, rst, item_stall |-> s1_valid && result_valid && result_stall, "input stalled with room in the pipeline")
  `ASSERT_CLK(a_no_write_on_read, clk, rd_en |-> !wr.wen, "payload write during a read command")

endmodule

`default_nettype wire

@@ sim/cfr_frame_checker_pkg.sv @@
`timescale 1ns / 1ps
// Frame checker class for the checksummed frame receiver bench: a byte-level
// parser that predicts every result, and the queue of results still awaited.
// Depends on cfr_pkg for the transaction types, status codes and frame bytes.
package cfr_frame_checker_pkg;
  import cfr_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LENGTH,
    PH_PAYLOAD,
    PH_CHECKSUM,
    PH_TAIL
  } parse_phase_t;

  class frame_checker;
    parse_phase_t phase;
    logic [7:0]   position;
    logic [6:0]   frame_words;
    logic         type_flag;
    logic [7:0]   running_sum;
    logic [7:0]   received_sum;
    logic [7:0]   payload [0:2*MAX_WORDS-1];
    int           bytes_filled;
    cfr_out_t     awaited_results [$];
    int           errors;

    function new();
      phase        = PH_HUNT;
      position     = '0;
      frame_words  = '0;
      type_flag    = 1'b0;
      running_sum  = '0;
      received_sum = '0;
      bytes_filled = 0;
      errors       = 0;
    endfunction

    // Payload writes always start at byte 0, so the written bytes form a prefix.
    function int words_ready();
      return bytes_filled / 2;
    endfunction

    function status_t parse_byte(logic [7:0] b);
      status_t st;
      st = ST_NONE;
      case (phase)
        PH_HUNT: begin
          if (position == 0) begin
            if (b == HDR_FIRST) position = 8'd1;
          end else begin
            position = '0;
            if (b == HDR_SECOND) phase = PH_LENGTH;
          end
        end
        PH_LENGTH: begin
          frame_words = b[7:1];
          type_flag   = |(b & TYPE_MASK);
          running_sum = '0;
          position    = '0;
          phase       = (frame_words == 0) ? PH_CHECKSUM : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          payload[position] = b;
          if (int'(position) + 1 > bytes_filled) bytes_filled = int'(position) + 1;
          running_sum = running_sum + b;
          position    = position + 8'd1;
          if (position >= {frame_words, 1'b0}) begin
            position = '0;
            phase    = PH_CHECKSUM;
          end
        end
        PH_CHECKSUM: begin
          received_sum = b;
          phase        = PH_TAIL;
        end
        PH_TAIL: begin
          if (b != TAIL_BYTE) st = ST_TAIL_ERR;
          else if (running_sum == received_sum) st = ST_GOOD;
          else st = ST_SUM_ERR;
          phase    = PH_HUNT;
          position = '0;
        end
        default: begin
          phase    = PH_HUNT;
          position = '0;
        end
      endcase
      return st;
    endfunction

    function void note_item(cfr_in_t it);
      cfr_out_t exp_res;
      exp_res = '0;
      if (it.command == CMD_BYTE) begin
        exp_res.frame_status = parse_byte(it.rx_byte);
      end else begin
        exp_res.word_value = {payload[2*it.word_index+1], payload[2*it.word_index]};
      end
      exp_res.word_count  = frame_words;
      exp_res.signed_flag = type_flag;
      awaited_results.push_back(exp_res);
    endfunction

    function void check_result(cfr_out_t got);
      cfr_out_t exp_res;
      if (awaited_results.size() == 0) begin
        errors++;
        $display("%0t: result with none awaited: actual %h", $time, got);
        return;
      end
      exp_res = awaited_results.pop_front();
      if (got.frame_status !== exp_res.frame_status) begin
        errors++;
        $display("%0t: frame_status expected %0d actual %0d", $time,
                 exp_res.frame_status, got.frame_status);
      end
      if (got.word_count !== exp_res.word_count) begin
        errors++;
        $display("%0t: word_count expected %0d actual %0d", $time,
                 exp_res.word_count, got.word_count);
      end
      if (got.signed_flag !== exp_res.signed_flag) begin
        errors++;
        $display("%0t: signed_flag expected %0d actual %0d", $time,
                 exp_res.signed_flag, got.signed_flag);
      end
      if (got.word_value !== exp_res.word_value) begin
        errors++;
        $display("%0t: word_value expected %h actual %h", $time,
                 exp_res.word_value, got.word_value);
      end
    endfunction
  endclass

endpackage

@@ sim/tb_checksummed_frame_receiver.sv @@
`timescale 1ns / 1ps
// Bench top for checksummed_frame_receiver: drives byte and read transactions,
// checks every result against frame_checker. Needs cfr_pkg, the RTL and
// cfr_frame_checker_pkg.
module tb_checksummed_frame_receiver;
  import cfr_pkg::*;
  import cfr_frame_checker_pkg::*;

  localparam int ITEM_TARGET  = 1550;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 80;
  localparam int RESET_CYCLES = 7;
  localparam int DRAIN_CYCLES = 8;

  typedef enum {FRAME_OK, FRAME_BAD_SUM, FRAME_BAD_TAIL, FRAME_CUT} frame_fault_t;

  logic     clk          = 1'b0;
  logic     rst          = 1'b1;
  logic     item_valid   = 1'b0;
  logic     item_stall;
  cfr_in_t  item         = '0;
  logic     result_valid;
  logic     result_stall = 1'b0;
  cfr_out_t result;

  frame_checker frame_sb;
  int       items_sent   = 0;
  int       cycles       = 0;
  int       hold_left    = 0;
  bit       quiet        = 1'b0;   // no idling on either side while set
  bit       hold_request = 1'b0;

  checksummed_frame_receiver dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #5 clk = ~clk;

  // Watchdog: end the run if the results never drain.
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("checksummed_frame_receiver test failed");
    $finish;
  end

  // Receiver side: stall at random, or hold off for a long stretch when asked
  // so the block fills up and pushes back on the sender.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= !quiet && ($urandom_range(99) < 14);
      end
    end
  end

  // Check each result transaction at the edge that takes it.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) frame_sb.check_result(result);
  end

  // Offer one transaction, with random idle cycles ahead of it; hold it
  // steady until the block takes it, then hand it to the checker.
  task automatic send_item(input cfr_in_t it);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 14) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    frame_sb.note_item(it);
    items_sent++;
  endtask

  // word_index is ignored for bytes; randomize it anyway to toggle its bits.
  task automatic send_byte(input logic [7:0] b);
    cfr_in_t it;
    it.command    = CMD_BYTE;
    it.rx_byte    = b;
    it.word_index = 7'($urandom_range(127));
    send_item(it);
  endtask

  task automatic send_read(input int idx);
    cfr_in_t it;
    it.command    = CMD_READ;
    it.rx_byte    = 8'($urandom_range(255));
    it.word_index = 7'(idx);
    send_item(it);
  endtask

  // Slip in a read of a word that some frame has already written.
  task automatic maybe_read();
    if (frame_sb.words_ready() > 0 && $urandom_range(99) < 20)
      send_read($urandom_range(frame_sb.words_ready() - 1));
  endtask

  // Send a whole frame with random payload; a fault corrupts the checksum,
  // replaces the tail, or cuts the frame short inside the payload.
  task automatic send_frame(input int n, input bit flag, input frame_fault_t fault);
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] tail;
    int         nbytes;
    int         i;
    sum    = '0;
    nbytes = (fault == FRAME_CUT) ? $urandom_range(2 * n) : 2 * n;
    send_byte(HDR_FIRST);
    maybe_read();
    send_byte(HDR_SECOND);
    send_byte({7'(n), flag});
    maybe_read();
    for (i = 0; i < nbytes; i++) begin
      b   = 8'($urandom_range(255));
      sum = sum + b;
      send_byte(b);
      maybe_read();
    end
    if (fault == FRAME_CUT) return;
    if (fault == FRAME_BAD_SUM) sum = sum ^ 8'($urandom_range(1, 255));
    send_byte(sum);
    maybe_read();
    tail = TAIL_BYTE;
    if (fault == FRAME_BAD_TAIL) begin
      while (tail == TAIL_BYTE) tail = 8'($urandom_range(255));
    end
    send_byte(tail);
  endtask

  // Opening sequence: empty good frame, header mismatch (second 0xEB is not
  // a fresh start), one signed word of all ones, tail error, checksum error.
  logic [7:0] opening_bytes [0:24] = '{
    8'hEB, 8'h90, 8'h00, 8'h00, 8'hBE,
    8'hEB, 8'hEB, 8'h90,
    8'hEB, 8'h90, 8'h03, 8'hFF, 8'hFF, 8'hFE, 8'hBE,
    8'hEB, 8'h90, 8'h01, 8'h00, 8'h00,
    8'hEB, 8'h90, 8'h00, 8'h07, 8'hBE
  };

  initial begin
    int           r;
    int           n;
    bit           pressed;
    frame_fault_t fault;
    frame_sb = new();
    pressed = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (opening_bytes[k]) send_byte(opening_bytes[k]);
    send_read(0);

    // Fill every word a frame can hold so reads can reach all of them.
    send_frame(MAX_WORDS - 1, 1'($urandom_range(1)), FRAME_OK);
    send_read(MAX_WORDS - 2);

    while (items_sent < ITEM_TARGET) begin
      // Run a stretch with no idling on either side.
      quiet = (items_sent > 300 && items_sent < 500);
      // Hold off the receiver once, while the sender keeps offering.
      if (!pressed && items_sent > 700) begin
        hold_request = 1'b1;
        pressed      = 1'b1;
      end
      r = $urandom_range(99);
      if (r < 8) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
      end else begin
        n = ($urandom_range(99) < 3) ? $urandom_range(64, MAX_WORDS - 1)
                                     : $urandom_range(0, 8);
        r = $urandom_range(99);
        if (r < 75) fault = FRAME_OK;
        else if (r < 84) fault = FRAME_BAD_SUM;
        else if (r < 93) fault = FRAME_BAD_TAIL;
        else fault = FRAME_CUT;
        send_frame(n, 1'($urandom_range(1)), fault);
      end
    end

    @(negedge clk);
    item_valid <= 1'b0;
    while (frame_sb.awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (frame_sb.errors == 0) begin
      $display("checksummed_frame_receiver test passed");
    end else begin
      $display("checksummed_frame_receiver test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/cfr_pkg.sv
rtl/cfr_store.sv
rtl/cfr_parser.sv
rtl/checksummed_frame_receiver.sv
sim/cfr_frame_checker_pkg.sv
sim/tb_checksummed_frame_receiver.sv
